### rtl/mf_pkg.sv
// Shared types and constants for the message fragmenter.
package mf_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 16;
  localparam int HDR_W     = 6;   // header size register and header counters
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;
  localparam int DIV_STEPS = 16;  // one quotient bit per cycle
  localparam int DIV_CNT_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SIZE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAG_MAX_SIZE = 1'd1;

  localparam logic [LEN_W-1:0] FRAG_MAX_RESET = 16'd1472;
  localparam logic [LEN_W-1:0] INDEX_BYTES    = 16'd4;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,  // waiting for an input word
    ST_DIV,   // fragment count division running
    ST_PROC,  // classify the latched byte
    ST_PFX,   // replay header, index and count bytes
    ST_BODY,  // send the latched body byte
    ST_BAD    // send the bad length word
  } state_t;

  // Header store write port
  typedef struct packed {
    logic              en;
    logic [HDR_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } ram_wr_t;

endpackage

### rtl/mf_hdr_ram.sv
// Header store: one write port, one registered read port with write forwarding.
module mf_hdr_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                      clk,
  input  mf_pkg::ram_wr_t           wr,
  input  logic [AW-1:0]             rd_addr,
  output logic [mf_pkg::BYTE_W-1:0] rd_data
);

  logic [mf_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [AW-1:0]             wa;

  assign wa = wr.addr[AW-1:0];

  // Write, and forward the written byte when the same entry is read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wa] <= wr.data;
    end
    if (wr.en && (wa == rd_addr)) begin
      rd_data <= wr.data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/mf_div.sv
// Restoring divider, one quotient bit per cycle, for the fragment count.
module mf_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [mf_pkg::LEN_W-1:0] num,
  input  logic [mf_pkg::LEN_W-1:0] den,
  output logic                     done,
  output logic [mf_pkg::LEN_W-1:0] quo
);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [mf_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [mf_pkg::LEN_W:0]       rem_r, rem_nxt;
  logic [mf_pkg::LEN_W-1:0]     quo_r, quo_nxt;
  logic [mf_pkg::LEN_W-1:0]     den_r, den_nxt;
  logic [mf_pkg::LEN_W:0]       rem_sh;
  logic                         ge;

  assign rem_sh = {rem_r[mf_pkg::LEN_W-1:0], quo_r[mf_pkg::LEN_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  // One shift-subtract step per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
      quo_nxt = {quo_r[mf_pkg::LEN_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == mf_pkg::DIV_CNT_W'(mf_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### rtl/message_fragmenter.sv
// Message fragmenter top level: control sequencer, header store and output register.
//
// Input channel (in_valid/in_ready) takes one message byte per word; the
// message length is sampled with the first byte. Output channel
// (out_valid/out_ready) gives one fragment byte per word, tagged with the
// fragment index, fragment count and end flags, or one bad_length word.
// Configuration (cfg_we/cfg_addr/cfg_wdata) is to be written by the user only
// between messages; the block itself does not enforce it.
//
// The first byte of a message waits for the 16-step fragment count divider.
// A header byte is written to the header store in ST_PROC. A body byte goes
// through ST_PROC, an ST_PFX replay of the header and the index and count
// bytes when it opens a fragment, and ST_BODY. The replay reads the header
// store through its registered read port, one byte per cycle unless stalled.
// A single output register holds the outgoing word: while it holds a word and
// out_ready is low the sequencer waits, the word stays put, and input words
// are taken again once the pending result is in that register.
// Reset (rst_n low, synchronous) clears the config to header 0 / fragment
// 1472, drops any message in progress and empties the output register.
module message_fragmenter #(
  parameter int MAX_HEADER = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [mf_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [mf_pkg::CFG_DAT_W-1:0] cfg_wdata,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mf_pkg::BYTE_W-1:0]    in_byte,
  input  logic [mf_pkg::LEN_W-1:0]     in_msg_length,
  // output channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mf_pkg::BYTE_W-1:0]    out_byte,
  output logic [mf_pkg::LEN_W-1:0]     out_frag_index,
  output logic [mf_pkg::LEN_W-1:0]     out_frag_count,
  output logic                         out_frag_end,
  output logic                         out_msg_end,
  output logic                         out_bad_length
);

  localparam int DEPTH = (MAX_HEADER > 0) ? MAX_HEADER : 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [mf_pkg::HDR_W-1:0] MAX_HDR = mf_pkg::HDR_W'(MAX_HEADER);

  // config registers
  logic [mf_pkg::HDR_W-1:0] hdr_size_r;
  logic [mf_pkg::LEN_W-1:0] frag_max_r;

  // sequencer state
  mf_pkg::state_t           st_r, st_nxt;
  logic                     in_msg_r, in_msg_nxt;
  logic [mf_pkg::BYTE_W-1:0] byte_r, byte_nxt;
  logic [mf_pkg::HDR_W-1:0] lat_hdr_r, lat_hdr_nxt;
  logic [mf_pkg::LEN_W-1:0] lat_body_r, lat_body_nxt;
  logic [mf_pkg::LEN_W-1:0] left_r, left_nxt;
  logic [mf_pkg::LEN_W-1:0] tot_r, tot_nxt;
  logic [mf_pkg::LEN_W-1:0] cur_r, cur_nxt;
  logic [mf_pkg::LEN_W-1:0] bb_r, bb_nxt;
  logic [mf_pkg::HDR_W-1:0] seen_r, seen_nxt;
  logic [mf_pkg::HDR_W-1:0] pc_r, pc_nxt;
  logic                     pfx_last_r, pfx_last_nxt;
  logic                     tb_zero_r, tb_zero_nxt;

  // output register
  logic                      ov_r, ov_nxt;
  logic [mf_pkg::BYTE_W-1:0] ob_r, ob_nxt;
  logic [mf_pkg::LEN_W-1:0]  oidx_r, oidx_nxt;
  logic [mf_pkg::LEN_W-1:0]  ocnt_r, ocnt_nxt;
  logic                      ofe_r, ofe_nxt;
  logic                      ome_r, ome_nxt;
  logic                      obad_r, obad_nxt;

  // datapath helpers
  logic                      accept, can_push;
  logic [mf_pkg::HDR_W-1:0]  hdr_clamp;
  logic [mf_pkg::LEN_W-1:0]  hdr_ext, hdr_plus4, body_calc, tb_calc;
  logic                      len_bad;
  logic [mf_pkg::LEN_W-1:0]  left_dec, bb_inc;
  logic                      last_msg, last_frag;
  logic [mf_pkg::HDR_W-1:0]  pfx_off;
  logic                      pfx_is_last;
  logic [mf_pkg::BYTE_W-1:0] pfx_byte;
  logic                      div_start, div_done;
  logic [mf_pkg::LEN_W-1:0]  div_quo;
  mf_pkg::ram_wr_t           ram_wr;
  logic [mf_pkg::BYTE_W-1:0] ram_q;

  assign in_ready = (st_r == mf_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign can_push = !ov_r || out_ready;

  // message setup arithmetic on the first byte
  assign hdr_clamp = (hdr_size_r > MAX_HDR) ? MAX_HDR : hdr_size_r;
  assign hdr_ext   = mf_pkg::LEN_W'(hdr_clamp);
  assign hdr_plus4 = hdr_ext + mf_pkg::INDEX_BYTES;
  assign len_bad   = in_msg_length < hdr_ext;
  assign body_calc = (frag_max_r > hdr_plus4) ? (frag_max_r - hdr_plus4)
                                              : mf_pkg::LEN_W'(1);
  assign tb_calc   = in_msg_length - hdr_ext;

  // per-byte counters
  assign left_dec  = left_r - 1'b1;
  assign bb_inc    = bb_r + 1'b1;
  assign last_msg  = (left_r == '0);
  assign last_frag = last_msg || (bb_inc >= lat_body_r);

  // prefix byte select: stored header, then index and count little endian
  assign pfx_off     = pc_r - lat_hdr_r;
  assign pfx_is_last = (pc_r == (lat_hdr_r + mf_pkg::HDR_W'(3)));
  always_comb begin
    pfx_byte = ram_q;
    if (pc_r >= lat_hdr_r) begin
      case (pfx_off[1:0])
        2'd0:    pfx_byte = cur_r[7:0];
        2'd1:    pfx_byte = cur_r[15:8];
        2'd2:    pfx_byte = tot_r[7:0];
        default: pfx_byte = tot_r[15:8];
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    st_nxt       = st_r;
    in_msg_nxt   = in_msg_r;
    byte_nxt     = byte_r;
    lat_hdr_nxt  = lat_hdr_r;
    lat_body_nxt = lat_body_r;
    left_nxt     = left_r;
    tot_nxt      = tot_r;
    cur_nxt      = cur_r;
    bb_nxt       = bb_r;
    seen_nxt     = seen_r;
    pc_nxt       = pc_r;
    pfx_last_nxt = pfx_last_r;
    tb_zero_nxt  = tb_zero_r;
    div_start    = 1'b0;
    ram_wr       = '0;
    ov_nxt       = ov_r && !out_ready;
    ob_nxt       = ob_r;
    oidx_nxt     = oidx_r;
    ocnt_nxt     = ocnt_r;
    ofe_nxt      = ofe_r;
    ome_nxt      = ome_r;
    obad_nxt     = obad_r;

    case (st_r)
      mf_pkg::ST_IDLE: begin
        if (accept) begin
          byte_nxt = in_byte;
          if (in_msg_r) begin
            st_nxt = mf_pkg::ST_PROC;
          end else if (len_bad) begin
            st_nxt = mf_pkg::ST_BAD;
          end else begin
            lat_hdr_nxt  = hdr_clamp;
            lat_body_nxt = body_calc;
            left_nxt     = in_msg_length;
            tb_zero_nxt  = (tb_calc == '0);
            cur_nxt      = '0;
            bb_nxt       = '0;
            seen_nxt     = '0;
            in_msg_nxt   = 1'b1;
            div_start    = 1'b1;
            st_nxt       = mf_pkg::ST_DIV;
          end
        end
      end

      mf_pkg::ST_DIV: begin
        if (div_done) begin
          tot_nxt = tb_zero_r ? mf_pkg::LEN_W'(1) : (div_quo + 1'b1);
          if (left_r == '0) begin
            // zero length message: the byte is not part of it
            in_msg_nxt   = 1'b0;
            pfx_last_nxt = 1'b1;
            pc_nxt       = '0;
            st_nxt       = mf_pkg::ST_PFX;
          end else begin
            st_nxt = mf_pkg::ST_PROC;
          end
        end
      end

      mf_pkg::ST_PROC: begin
        left_nxt = left_dec;
        if (seen_r < lat_hdr_r) begin
          ram_wr.en   = 1'b1;
          ram_wr.addr = seen_r;
          ram_wr.data = byte_r;
          seen_nxt    = seen_r + 1'b1;
          if (left_dec == '0) begin
            // message without body: one prefix-only fragment
            in_msg_nxt   = 1'b0;
            pfx_last_nxt = 1'b1;
            pc_nxt       = '0;
            st_nxt       = mf_pkg::ST_PFX;
          end else begin
            st_nxt = mf_pkg::ST_IDLE;
          end
        end else if (bb_r == '0) begin
          pfx_last_nxt = 1'b0;
          pc_nxt       = '0;
          st_nxt       = mf_pkg::ST_PFX;
        end else begin
          st_nxt = mf_pkg::ST_BODY;
        end
      end

      mf_pkg::ST_PFX: begin
        if (can_push) begin
          ov_nxt   = 1'b1;
          ob_nxt   = pfx_byte;
          oidx_nxt = cur_r;
          ocnt_nxt = tot_r;
          ofe_nxt  = pfx_last_r && pfx_is_last;
          ome_nxt  = pfx_last_r && pfx_is_last;
          obad_nxt = 1'b0;
          if (pfx_is_last) begin
            st_nxt = pfx_last_r ? mf_pkg::ST_IDLE : mf_pkg::ST_BODY;
          end else begin
            pc_nxt = pc_r + 1'b1;
          end
        end
      end

      mf_pkg::ST_BODY: begin
        if (can_push) begin
          ov_nxt   = 1'b1;
          ob_nxt   = byte_r;
          oidx_nxt = cur_r;
          ocnt_nxt = tot_r;
          ofe_nxt  = last_frag;
          ome_nxt  = last_msg;
          obad_nxt = 1'b0;
          if (last_frag) begin
            cur_nxt = cur_r + 1'b1;
            bb_nxt  = '0;
          end else begin
            bb_nxt = bb_inc;
          end
          if (last_msg) begin
            in_msg_nxt = 1'b0;
          end
          st_nxt = mf_pkg::ST_IDLE;
        end
      end

      mf_pkg::ST_BAD: begin
        if (can_push) begin
          ov_nxt   = 1'b1;
          ob_nxt   = '0;
          oidx_nxt = '0;
          ocnt_nxt = '0;
          ofe_nxt  = 1'b0;
          ome_nxt  = 1'b0;
          obad_nxt = 1'b1;
          st_nxt   = mf_pkg::ST_IDLE;
        end
      end

      default: begin
        st_nxt = mf_pkg::ST_IDLE;
      end
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_size_r <= '0;
      frag_max_r <= mf_pkg::FRAG_MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        mf_pkg::CFG_HEADER_SIZE:   hdr_size_r <= cfg_wdata[mf_pkg::HDR_W-1:0];
        mf_pkg::CFG_FRAG_MAX_SIZE: frag_max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= mf_pkg::ST_IDLE;
      in_msg_r   <= 1'b0;
      left_r     <= '0;
      tot_r      <= '0;
      cur_r      <= '0;
      bb_r       <= '0;
      seen_r     <= '0;
      lat_hdr_r  <= '0;
      lat_body_r <= '0;
      pc_r       <= '0;
      pfx_last_r <= 1'b0;
      tb_zero_r  <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      in_msg_r   <= in_msg_nxt;
      left_r     <= left_nxt;
      tot_r      <= tot_nxt;
      cur_r      <= cur_nxt;
      bb_r       <= bb_nxt;
      seen_r     <= seen_nxt;
      lat_hdr_r  <= lat_hdr_nxt;
      lat_body_r <= lat_body_nxt;
      pc_r       <= pc_nxt;
      pfx_last_r <= pfx_last_nxt;
      tb_zero_r  <= tb_zero_nxt;
      ov_r       <= ov_nxt;
    end
    byte_r <= byte_nxt;
    ob_r   <= ob_nxt;
    oidx_r <= oidx_nxt;
    ocnt_r <= ocnt_nxt;
    ofe_r  <= ofe_nxt;
    ome_r  <= ome_nxt;
    obad_r <= obad_nxt;
  end

  // fragment count: (body bytes - 1) / body size, plus one
  mf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (tb_calc - 1'b1),
    .den   (body_calc),
    .done  (div_done),
    .quo   (div_quo)
  );

  // header store, addressed with the next prefix count so its registered output matches the prefix counter
  mf_hdr_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_addr (pc_nxt[AW-1:0]),
    .rd_data (ram_q)
  );

  assign out_valid      = ov_r;
  assign out_byte       = ob_r;
  assign out_frag_index = oidx_r;
  assign out_frag_count = ocnt_r;
  assign out_frag_end   = ofe_r;
  assign out_msg_end    = ome_r;
  assign out_bad_length = obad_r;

endmodule

### rtl/mf_checker.sv
// Port-level checks for the message fragmenter, bound to the top level.
module mf_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [mf_pkg::BYTE_W-1:0]    out_byte,
  input logic [mf_pkg::LEN_W-1:0]     out_frag_index,
  input logic [mf_pkg::LEN_W-1:0]     out_frag_count,
  input logic                         out_frag_end,
  input logic                         out_msg_end,
  input logic                         out_bad_length
);

  // stalled word holds its valid, byte, index and message end
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_frag_index) && $stable(out_msg_end))
    else $error("output word changed while stalled");

  // bad length word carries nothing else
  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_length |-> out_byte == 8'd0 && out_frag_index == 16'd0 &&
      out_frag_count == 16'd0 && !out_frag_end && !out_msg_end)
    else $error("bad length word has nonzero fields");

  // message end closes a fragment
  a_msg_frag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_msg_end |-> out_frag_end)
    else $error("message end without fragment end");

  // fragment index stays below the count
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_length |-> out_frag_index < out_frag_count)
    else $error("fragment index out of range");

endmodule

bind message_fragmenter mf_checker u_mf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_byte       (out_byte),
  .out_frag_index (out_frag_index),
  .out_frag_count (out_frag_count),
  .out_frag_end   (out_frag_end),
  .out_msg_end    (out_msg_end),
  .out_bad_length (out_bad_length)
);

### test/mf_checker.sv
// Scoreboard for the message fragmenter: predicts fragment words and compares them.
module mf_scoreboard #(
  parameter int MAX_HEADER = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [mf_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [mf_pkg::CFG_DAT_W-1:0] cfg_wdata,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [mf_pkg::BYTE_W-1:0]    in_byte,
  input  logic [mf_pkg::LEN_W-1:0]     in_msg_length,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [mf_pkg::BYTE_W-1:0]    out_byte,
  input  logic [mf_pkg::LEN_W-1:0]     out_frag_index,
  input  logic [mf_pkg::LEN_W-1:0]     out_frag_count,
  input  logic                         out_frag_end,
  input  logic                         out_msg_end,
  input  logic                         out_bad_length,
  output int                           failures,
  output int                           pending
);
  import mf_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  idx;
    logic [LEN_W-1:0]  cnt;
    logic              fend;
    logic              mend;
    logic              bad;
  } frag_word_t;

  frag_word_t frag_words_q[$];
  int         mismatches = 0;

  // register copies
  logic [HDR_W-1:0] hdr_reg;
  logic [LEN_W-1:0] fmax_reg;

  // message state
  logic [BYTE_W-1:0] hdr_mem [0:MAX_HEADER-1];
  logic [LEN_W-1:0]  left_cnt;
  logic [LEN_W-1:0]  frag_total;
  logic [LEN_W-1:0]  frag_cur;
  logic [LEN_W-1:0]  body_cnt;
  logic              in_msg;
  int                hdr_len;
  int                body_len;
  int                hdr_got;

  task automatic push_word(input logic [BYTE_W-1:0] b, input logic fe, input logic me);
    frag_word_t w;
    w.data = b;
    w.idx  = frag_cur;
    w.cnt  = frag_total;
    w.fend = fe;
    w.mend = me;
    w.bad  = 1'b0;
    frag_words_q.push_back(w);
  endtask

  // header replay, then index and count little-endian; ends flags go on count high
  task automatic push_prefix(input logic ends);
    for (int i = 0; i < hdr_len; i++) push_word(hdr_mem[i], 1'b0, 1'b0);
    push_word(frag_cur[7:0], 1'b0, 1'b0);
    push_word(frag_cur[15:8], 1'b0, 1'b0);
    push_word(frag_total[7:0], 1'b0, 1'b0);
    push_word(frag_total[15:8], ends, ends);
  endtask

  // expected words for one accepted message byte
  task automatic fragment_byte(input logic [BYTE_W-1:0] b, input logic [LEN_W-1:0] len);
    int         hdr_eff;
    int         body_sz;
    int         body_total;
    logic       last_msg;
    logic       last_frag;
    frag_word_t w;
    if (!in_msg) begin
      hdr_eff = (hdr_reg > MAX_HEADER) ? MAX_HEADER : hdr_reg;
      if (len < hdr_eff) begin
        // length below header: lone error word, byte dropped
        w = '0;
        w.bad = 1'b1;
        frag_words_q.push_back(w);
        return;
      end
      body_sz    = (fmax_reg > hdr_eff + 4) ? fmax_reg - hdr_eff - 4 : 1;
      body_total = len - hdr_eff;
      frag_total = LEN_W'((body_total == 0) ? 1 : (body_total + body_sz - 1) / body_sz);
      hdr_len    = hdr_eff;
      body_len   = body_sz;
      hdr_got    = 0;
      frag_cur   = '0;
      body_cnt   = '0;
      left_cnt   = len;
      in_msg     = 1'b1;
      if (len == 0) begin
        // zero length, zero header: byte dropped, bare index fragment
        push_prefix(1'b1);
        in_msg = 1'b0;
        return;
      end
    end
    left_cnt = left_cnt - 1'b1;
    if (hdr_got < hdr_len) begin
      hdr_mem[hdr_got] = b;
      hdr_got++;
      // empty body: single prefix-only fragment
      if (left_cnt == 0) begin
        push_prefix(1'b1);
        in_msg = 1'b0;
      end
      return;
    end
    last_msg = (left_cnt == 0);
    if (body_cnt == 0) push_prefix(1'b0);
    body_cnt++;
    last_frag = last_msg || (body_cnt >= body_len);
    push_word(b, last_frag, last_msg);
    if (last_frag) begin
      frag_cur++;
      body_cnt = '0;
    end
    if (last_msg) in_msg = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [LEN_W-1:0] want,
                             input logic [LEN_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_word(input frag_word_t got);
    frag_word_t want;
    if (frag_words_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
      return;
    end
    want = frag_words_q.pop_front();
    check_field("out_byte", LEN_W'(want.data), LEN_W'(got.data));
    check_field("out_frag_index", want.idx, got.idx);
    check_field("out_frag_count", want.cnt, got.cnt);
    check_field("out_frag_end", LEN_W'(want.fend), LEN_W'(got.fend));
    check_field("out_msg_end", LEN_W'(want.mend), LEN_W'(got.mend));
    check_field("out_bad_length", LEN_W'(want.bad), LEN_W'(got.bad));
  endtask

  // monitor: results first, then the input word taken at the same edge
  always @(posedge clk) begin
    frag_word_t got;
    if (!rst_n) begin
      hdr_reg    = '0;
      fmax_reg   = FRAG_MAX_RESET;
      in_msg     = 1'b0;
      frag_total = '0;
      frag_cur   = '0;
      body_cnt   = '0;
      left_cnt   = '0;
      frag_words_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.data = out_byte;
        got.idx  = out_frag_index;
        got.cnt  = out_frag_count;
        got.fend = out_frag_end;
        got.mend = out_msg_end;
        got.bad  = out_bad_length;
        check_word(got);
      end
      if (cfg_we) begin
        if (cfg_addr == CFG_HEADER_SIZE) hdr_reg = cfg_wdata[HDR_W-1:0];
        else if (cfg_addr == CFG_FRAG_MAX_SIZE) fmax_reg = cfg_wdata;
      end
      if (in_valid && in_ready) fragment_byte(in_byte, in_msg_length);
    end
    failures <= mismatches;
    pending  <= frag_words_q.size();
  end

endmodule

### test/tb_message_fragmenter.sv
// Testbench top for the message fragmenter: clock, reset, stimulus and verdict.
module tb_message_fragmenter;
  import mf_pkg::*;

  localparam int MAX_HEADER = 32;
  localparam int IDLE_LIMIT = 2000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_byte = '0;
  logic [LEN_W-1:0]     in_msg_length = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [BYTE_W-1:0]    out_byte;
  logic [LEN_W-1:0]     out_frag_index;
  logic [LEN_W-1:0]     out_frag_count;
  logic                 out_frag_end;
  logic                 out_msg_end;
  logic                 out_bad_length;

  int failures;
  int pending;

  // traffic shaping
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int stall_pct = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int item_total = 0;

  // config as the block sees it
  int hdr_eff = 0;
  int body_len = 1468;

  message_fragmenter #(.MAX_HEADER(MAX_HEADER)) DUT (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata,
    .in_valid, .in_ready, .in_byte, .in_msg_length,
    .out_valid, .out_ready, .out_byte, .out_frag_index, .out_frag_count,
    .out_frag_end, .out_msg_end, .out_bad_length
  );

  mf_scoreboard #(.MAX_HEADER(MAX_HEADER)) checker_i (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata,
    .in_valid, .in_ready, .in_byte, .in_msg_length,
    .out_valid, .out_ready, .out_byte, .out_frag_index, .out_frag_count,
    .out_frag_end, .out_msg_end, .out_bad_length,
    .failures, .pending
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: random stall runs at a per-phase rate
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog: no word moving on any port for too long
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_cfg(input logic [CFG_DAT_W-1:0] hdr_w, input logic [CFG_DAT_W-1:0] fmax_w);
    write_reg(CFG_HEADER_SIZE, hdr_w);
    write_reg(CFG_FRAG_MAX_SIZE, fmax_w);
    hdr_eff = (hdr_w[HDR_W-1:0] > MAX_HEADER) ? MAX_HEADER : hdr_w[HDR_W-1:0];
    body_len = (fmax_w > hdr_eff + 4) ? fmax_w - hdr_eff - 4 : 1;
  endtask

  // one input word; valid stays up inside a burst
  task automatic send_word(input logic [BYTE_W-1:0] b, input logic [LEN_W-1:0] len);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(1, 20) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_msg_length <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    item_total++;
  endtask

  // whole message; length field is noise after the first byte
  task automatic send_message(input int len);
    send_word(BYTE_W'($urandom), LEN_W'(len));
    if (len < hdr_eff || len == 0) return;
    for (int i = 1; i < len; i++) send_word(BYTE_W'($urandom), LEN_W'($urandom));
  endtask

  // drop valid, drain expected words, let the block settle
  task automatic end_phase();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic int pick_length();
    int r;
    int cap;
    r = $urandom_range(0, 99);
    cap = (body_len * 3 + 1 > 40) ? 40 : body_len * 3 + 1;
    if (r < 8) return (hdr_eff > 0) ? $urandom_range(0, hdr_eff - 1) : 0;
    if (r < 14) return hdr_eff;
    return hdr_eff + $urandom_range(1, cap);
  endfunction

  initial begin
    int h;
    int fm;
    int sel;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: zero length with no header, one-byte and two-byte bodies
    send_word(8'h00, 16'd0);
    send_word(8'hFF, 16'd1);
    send_word(8'h00, 16'd2);
    send_word(8'hFF, 16'hFFFF);
    end_phase();

    // two-byte header, body of one: short length, empty body, two fragments
    set_cfg(16'hFFC2, 16'd7);
    send_word(8'hA5, 16'd1);
    send_word(8'h00, 16'd2);
    send_word(8'hFF, 16'd0);
    send_word(8'h11, 16'd4);
    send_word(8'h22, 16'hAAAA);
    send_word(8'h00, 16'h5555);
    send_word(8'hFF, 16'h0000);
    end_phase();

    // saturated header with largest fragment: lengths below the header
    set_cfg(16'h003F, 16'hFFFF);
    send_word(8'h5A, 16'd0);
    send_word(8'hC3, 16'd31);
    end_phase();

    // fragment too small for header and index: body clamps to one
    set_cfg(16'd1, 16'd5);
    send_word(8'h01, 16'd3);
    send_word(8'h80, 16'd0);
    send_word(8'h7F, 16'd0);
    end_phase();

    // random phases: new config, a few messages, traffic shape per phase
    item_total = 0;
    while (item_total < 340) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0: h = 0;
        1: h = 32;
        2: h = 63;
        3: h = $urandom_range(33, 62);
        default: h = $urandom_range(1, 8);
      endcase
      fm = ((h > MAX_HEADER) ? MAX_HEADER : h) + 4;
      sel = $urandom_range(0, 9);
      case (sel)
        0: fm = 5;
        1: fm = 65535;
        2: fm = 1472;
        3: fm = (fm < 5) ? 5 : fm;
        default: fm = fm + $urandom_range(1, 8);
      endcase
      set_cfg({10'($urandom_range(0, 1023)), 6'(h)}, 16'(fm));
      gaps_on = ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 3);
      case (sel)
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 80;
      endcase
      repeat ($urandom_range(2, 5)) send_message(pick_length());
      end_phase();
    end

    // one long message without gaps or stalls, split into a 64-byte and a 36-byte fragment
    set_cfg(16'hFFC0, 16'd68);
    gaps_on = 1'b0;
    stall_pct = 0;
    send_message(100);
    end_phase();

    repeat (100) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/mf_pkg.sv
rtl/mf_hdr_ram.sv
rtl/mf_div.sv
rtl/message_fragmenter.sv
rtl/mf_checker.sv
test/mf_checker.sv
test/tb_message_fragmenter.sv
